>>> rtl/bitmap_page_allocator_macros.svh
// Assertion helpers used by the checker file.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap page allocator check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap page allocator check failed");

`endif

>>> rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

  localparam int MAX_PAGES     = 64;
  localparam int IDX_W         = 6;
  localparam int ADDR_W        = 48;
  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int NUM_PAGES_DEF = 64;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 4;

  typedef enum logic [1:0] {
    CMD_RESERVE   = 2'd0,
    CMD_FREE_IDX  = 2'd1,
    CMD_FREE_ADDR = 2'd2,
    CMD_RELEASE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_NOT_RESERVED = 3'd2,
    ST_MISALIGNED   = 3'd3,
    ST_RANGE        = 3'd4
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_release;
    logic rel_empty;
    logic rel_last;
    logic out_free;
  } dp_stat_t;

  // Lowest set bit: {found, index}.
  function automatic logic [IDX_W:0] first_one(input logic [MAX_PAGES-1:0] v);
    logic [IDX_W:0] res;
    res = '0;
    for (int i = MAX_PAGES - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b1, IDX_W'(i)};
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bitmap_page_allocator.sv
// Channel   Dir  Handshake         Contents
// s_*       in   s_tvalid/tready   command in tuser, page index and address in tdata
// m_*       out  m_tvalid/tready   status in tuser, page result in tdata, tlast
// APB       in   psel/penable      heap_base at byte address 0 (64-bit data)
//
// Reserve and both frees pass through these steps from acceptance to the next ready:
// accept, decode (priority encoder or address check), then result.
// Release-all loops through decode and result, one freed page per pass
// through the same encoder and adder; an empty map gives no item.
// Reset is synchronous and clears the page map and heap_base.
// A stalled output holds the block in its result step until the item is taken.
`default_nettype none

module bitmap_page_allocator #(
  parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [55:0]                    s_tdata,  // page_index[5:0], address[53:6], pad
  input  wire logic [1:0]                     s_tuser,  // command[1:0]
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // result_index[5:0], page_address[53:6], entry_update[54], entry_present[55]
  output logic [55:0]                         m_tdata,
  output logic [2:0]                          m_tuser,  // status[2:0]
  output logic                                m_tlast,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bpa_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [bpa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bpa_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import bpa_pkg::*;

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic              cfg_we;
  logic              sel_base;
  logic [ADDR_W-1:0] heap_base;
  status_t           res_status;
  logic [IDX_W-1:0]  res_index;
  logic [ADDR_W-1:0] res_address;
  logic              res_update;
  logic              res_present;

  // One 8-byte register; bit 3 selects the word.
  assign sel_base = !paddr[3];
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready && sel_base;
  assign prdata   = sel_base ? CFG_DATA_W'(heap_base) : '0;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpa_datapath #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (s_tuser),
    .in_page_index (s_tdata[5:0]),
    .in_address    (s_tdata[53:6]),
    .cfg_we        (cfg_we),
    .cfg_wdata     (pwdata[ADDR_W-1:0]),
    .heap_base     (heap_base),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .res_status    (res_status),
    .res_index     (res_index),
    .res_address   (res_address),
    .res_update    (res_update),
    .res_present   (res_present),
    .res_last      (m_tlast)
  );

  assign m_tdata = {res_present, res_update, res_address, res_index};
  assign m_tuser = res_status;

endmodule

`default_nettype wire

>>> rtl/bpa_ctrl.sv
`default_nettype none

module bpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire bpa_pkg::dp_stat_t  stat,
  output bpa_pkg::ctrl_cmd_t      cmd
);
  import bpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        // Ready is still low in the first cycle after reset.
        cmd.load = s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // Release-all on an empty map ends without any item.
        if (stat.rel_empty) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = (stat.is_release && !stat.rel_last) ? S_DECODE : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b0;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == S_IDLE);
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpa_datapath.sv
`default_nettype none

module bpa_datapath #(
  parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bpa_pkg::ctrl_cmd_t         cmd,
  output bpa_pkg::dp_stat_t               stat,
  input  wire logic [1:0]                 in_command,
  input  wire logic [bpa_pkg::IDX_W-1:0]  in_page_index,
  input  wire logic [bpa_pkg::ADDR_W-1:0] in_address,
  input  wire logic                       cfg_we,
  input  wire logic [bpa_pkg::ADDR_W-1:0] cfg_wdata,
  output logic [bpa_pkg::ADDR_W-1:0]      heap_base,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output bpa_pkg::status_t                res_status,
  output logic [bpa_pkg::IDX_W-1:0]       res_index,
  output logic [bpa_pkg::ADDR_W-1:0]      res_address,
  output logic                            res_update,
  output logic                            res_present,
  output logic                            res_last
);
  import bpa_pkg::*;

  localparam int PG_W = ADDR_W - PAGE_SHIFT;

  logic [NUM_PAGES-1:0] used_map;
  logic [MAX_PAGES-1:0] map_ext;
  logic [MAX_PAGES-1:0] valid_mask;
  logic [MAX_PAGES-1:0] idx_bit;
  logic [MAX_PAGES-1:0] map_new;

  cmd_t              cmd_q;
  logic [IDX_W-1:0]  pidx_q;
  logic [ADDR_W-1:0] addr_q;
  logic [IDX_W-1:0]  idx_q;
  logic              found_q;
  logic              pre_err_q;
  status_t           pre_st_q;

  logic [ADDR_W-1:0] off;
  logic              below;
  logic              misaligned;
  logic              past_end;
  logic [IDX_W:0]    enc_free;
  logic [IDX_W:0]    enc_used;

  logic [ADDR_W-1:0] pg_addr;
  logic              hit;
  logic [MAX_PAGES-1:0] cleared;
  status_t           e_status;
  logic [IDX_W-1:0]  e_index;
  logic [ADDR_W-1:0] e_address;
  logic              e_update;
  logic              e_present;
  logic              e_last;

  assign map_ext    = MAX_PAGES'(used_map);
  assign valid_mask = MAX_PAGES'({NUM_PAGES{1'b1}});
  assign enc_free   = first_one(~map_ext & valid_mask);
  assign enc_used   = first_one(map_ext);

  // Address decode for free by address.
  assign below      = addr_q < heap_base;
  assign off        = addr_q - heap_base;
  assign misaligned = |off[PAGE_SHIFT-1:0];
  assign past_end   = off[ADDR_W-1:PAGE_SHIFT] >= PG_W'(NUM_PAGES);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= cmd_t'(in_command);
      pidx_q <= in_page_index;
      addr_q <= in_address;
    end
    if (cmd.decode) begin
      found_q   <= 1'b0;
      pre_err_q <= 1'b0;
      pre_st_q  <= ST_OK;
      case (cmd_q)
        CMD_RESERVE:  {found_q, idx_q} <= enc_free;
        CMD_FREE_IDX: idx_q <= pidx_q;
        CMD_FREE_ADDR: begin
          idx_q     <= off[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT];
          pre_err_q <= below || misaligned || past_end;
          pre_st_q  <= (!below && misaligned) ? ST_MISALIGNED : ST_RANGE;
        end
        default:      {found_q, idx_q} <= enc_used;
      endcase
    end
  end

  // Result and map update for the decoded page.
  assign pg_addr = heap_base + (ADDR_W'(idx_q) << PAGE_SHIFT);
  assign idx_bit = MAX_PAGES'(1) << idx_q;
  assign hit     = |(map_ext & idx_bit);
  assign cleared = map_ext & ~idx_bit;

  always_comb begin
    e_status  = ST_OK;
    e_index   = idx_q;
    e_address = pg_addr;
    e_update  = 1'b1;
    e_present = 1'b0;
    e_last    = 1'b1;
    map_new   = map_ext;
    case (cmd_q)
      CMD_RESERVE: begin
        if (found_q) begin
          e_present = 1'b1;
          map_new   = map_ext | idx_bit;
        end else begin
          e_status  = ST_FULL;
          e_index   = '0;
          e_address = '0;
          e_update  = 1'b0;
        end
      end
      CMD_FREE_IDX, CMD_FREE_ADDR: begin
        if ((cmd_q == CMD_FREE_ADDR) && pre_err_q) begin
          e_status  = pre_st_q;
          e_index   = '0;
          e_address = '0;
          e_update  = 1'b0;
        end else if (hit) begin
          map_new = cleared;
        end else begin
          e_status = ST_NOT_RESERVED;
          e_update = 1'b0;
        end
      end
      default: begin
        map_new = cleared;
        e_last  = ~|cleared;
      end
    endcase
  end

  assign stat.is_release = (cmd_q == CMD_RELEASE);
  assign stat.rel_empty  = (cmd_q == CMD_RELEASE) && !found_q;
  assign stat.rel_last   = ~|cleared;
  assign stat.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map  <= '0;
      heap_base <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_base <= cfg_wdata;
      end
      if (cmd.emit) begin
        used_map <= map_new[NUM_PAGES-1:0];
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_status  <= e_status;
      res_index   <= e_index;
      res_address <= e_address;
      res_update  <= e_update;
      res_present <= e_present;
      res_last    <= e_last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpa_checker.sv
`default_nettype none

`include "bitmap_page_allocator_macros.svh"

module bpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);
  import bpa_pkg::*;

  // A waiting output item must not change.
  `BPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // The block works on one item at a time.
  `BPA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

  // A successful item always rewrites a page-table entry.
  `BPA_ASSERT_NOW(a_ok_updates, m_tvalid && (m_tuser == ST_OK), m_tdata[54])

  // An error item is the only item of its command and changes nothing.
  `BPA_ASSERT_NOW(a_err_single, m_tvalid && (m_tuser != ST_OK), m_tlast && !m_tdata[54] && !m_tdata[55])

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

`default_nettype wire
